>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is high.
`define ASSERT_ON(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that also runs across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/pfa_pkg.sv
// Shared types and codes for the partition fit allocator.
`default_nettype none

package pfa_pkg;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic REG_FIT_MODE      = 1'b0;
  localparam logic REG_BLOCKS_IN_USE = 1'b1;

  // Control into the fit unit.
  typedef struct packed {
    logic       found;
    logic [1:0] mode;
  } fit_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/pfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/pfa_fit_unit.sv
// Shared subtract and compare unit: fit test, policy compare, remaining size.
`default_nettype none

module pfa_fit_unit
  import pfa_pkg::*;
#(
  parameter int SIZE_BITS = 16
) (
  input  wire fit_ctrl_t            ctrl,
  input  wire logic [SIZE_BITS-1:0] val,
  input  wire logic [SIZE_BITS-1:0] best,
  input  wire logic [SIZE_BITS-1:0] amt,
  output logic                      take,
  output logic      [SIZE_BITS-1:0] diff
);

  logic                 borrow;
  logic                 better;

  assign {borrow, diff} = {1'b0, val} - {1'b0, amt};

  always_comb begin
    case (ctrl.mode)
      FIT_BEST:  better = (val < best);
      FIT_WORST: better = (val > best);
      default:   better = 1'b0;
    endcase
  end

  // Keep the earliest fit unless the policy finds a strictly better one.
  assign take = !borrow && (!ctrl.found || better);

endmodule

`default_nettype wire

>>> rtl/partition_fit_allocator_top.sv
// Partition fit allocator: free-size table, scan sequencer and output register.
// Load item: the write state registers the result, then goes idle once output is free.
// Allocate item: L = min(blocks_in_use, NUM_BLOCKS) reads, one per cycle on the single
// RAM read port, then the write state; no new item is taken until back in idle.
// The result register lets the next item enter while a result waits to be taken.
// Synchronous reset: table reads zero (valid bits), count 0, fit_mode 0, blocks_in_use 16.
`default_nettype none

module partition_fit_allocator_top
  import pfa_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // block_index[3:0], amount[19:4], zero pad
  input  wire logic        s_tuser,   // opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // block_number[3:0], remaining[19:4],
                                      // request_number[35:20], zero pad
  output logic             m_tuser,   // granted
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic  [4:0] cfg_data
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t               state;
  logic [1:0]           fit_mode;
  logic [4:0]           blocks_in_use;
  logic [15:0]          req_count;
  logic [SIZE_BITS-1:0] amt;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     limit_next;
  logic [CNT_W-1:0]     cnt;
  logic                 cmp_live;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] best;
  logic [NUM_BLOCKS-1:0] valid;

  logic                 accept;
  logic                 is_load;
  logic                 load_ok;
  logic                 out_free;
  logic [SIZE_BITS-1:0] amt_in;
  logic [LIM_W-1:0]     biu_ext;
  logic                 issue;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic [IDX_W-1:0]     rd_addr;
  logic [SIZE_BITS-1:0] rd_data;
  logic [SIZE_BITS-1:0] cmp_val;
  logic [SIZE_BITS-1:0] unit_val;
  fit_ctrl_t            unit_ctrl;
  logic                 take;
  logic [SIZE_BITS-1:0] diff;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_load  = (s_tuser == OP_LOAD);
  assign load_ok  = (32'(s_tdata[3:0]) < NUM_BLOCKS);
  assign amt_in   = SIZE_BITS'(s_tdata[19:4]);
  assign out_free = !m_tvalid || m_tready;

  // Clamp the scan length to the table depth.
  assign biu_ext    = LIM_W'(blocks_in_use);
  assign limit_next = (biu_ext > LIM_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(biu_ext);

  assign issue   = (state == ST_SCAN) && (cnt < limit);
  assign rd_addr = cnt[IDX_W-1:0];

  // Write port: loads at accept, the chosen entry when the result is registered.
  always_comb begin
    if (state == ST_WRITE) begin
      wr_en   = found && out_free;
      wr_addr = pick;
      wr_data = diff;
    end else begin
      wr_en   = accept && is_load && load_ok;
      wr_addr = IDX_W'(s_tdata[3:0]);
      wr_data = amt_in;
    end
  end

  pfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cmp_val        = cmp_vld ? rd_data : '0;
  assign unit_val       = (state == ST_WRITE) ? best : cmp_val;
  assign unit_ctrl.found = found;
  assign unit_ctrl.mode  = fit_mode;

  pfa_fit_unit #(
    .SIZE_BITS (SIZE_BITS)
  ) u_fit (
    .ctrl (unit_ctrl),
    .val  (unit_val),
    .best (best),
    .amt  (amt),
    .take (take),
    .diff (diff)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode      <= FIT_FIRST;
      blocks_in_use <= 5'd16;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FIT_MODE:      fit_mode      <= cfg_data[1:0];
        REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data;
        default:           fit_mode      <= fit_mode;
      endcase
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      req_count <= '0;
      cmp_live  <= 1'b0;
      found     <= 1'b0;
      cnt       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            found    <= 1'b0;
            cnt      <= '0;
            cmp_live <= 1'b0;
            if (is_load) begin
              state <= ST_WRITE;
            end else begin
              req_count <= req_count + 16'd1;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cmp_live <= issue;
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end else begin
            state <= ST_WRITE;
          end
          if (cmp_live && take) begin
            found <= 1'b1;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Scan datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      amt   <= amt_in;
      limit <= limit_next;
    end
    if (issue) begin
      cmp_idx <= cnt[IDX_W-1:0];
      cmp_vld <= valid[cnt[IDX_W-1:0]];
    end
    if (state == ST_SCAN && cmp_live && take) begin
      pick <= cmp_idx;
      best <= cmp_val;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_WRITE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && out_free) begin
      m_tuser        <= found;
      m_tdata[3:0]   <= found ? 4'(pick) : 4'd0;
      m_tdata[19:4]  <= found ? 16'(diff) : 16'd0;
      m_tdata[35:20] <= req_count;
      m_tdata[39:36] <= 4'd0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pfa_checker.sv
// Port-level checker for the partition fit allocator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pfa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic        m_tuser,
  input wire logic [39:0] m_tdata
);

  `ASSERT_ON(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `ASSERT_ON(a_busy_after_accept, clk, rst, s_tvalid && s_tready |=> !s_tready, "item taken while busy")
  `ASSERT_ON(a_no_grant_zero, clk, rst, m_tvalid && !m_tuser |-> m_tdata[19:0] == 20'd0, "no-grant result carries partition data")
  `ASSERT_ALWAYS(a_reset_state, clk, rst |=> !m_tvalid && s_tready, "reset did not clear the block")

endmodule

bind partition_fit_allocator_top pfa_checker u_pfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata)
);

`default_nettype wire
